### rtl/core/sndc_pkg.sv
// Shared types and constants for the signed number to digit code converter.
`default_nettype none

package sndc_pkg;

    localparam int DEF_NUM_DIGITS = 8;
    localparam int NUMBER_W       = 32;
    localparam int CODE_W         = 8;
    localparam int POINT_W        = 8;
    localparam int DIGIT_INDEX_W  = 3;
    localparam int CFG_INDEX_W    = 2;
    localparam int BCD_W          = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_CODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DASH_CODE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_MASK = 2'd2;

    localparam logic [CODE_W-1:0] ZERO_CODE_RST  = 8'd0;
    localparam logic [CODE_W-1:0] DASH_CODE_RST  = 8'd10;
    localparam logic [CODE_W-1:0] POINT_MASK_RST = 8'd128;

    // Reciprocal of ten: (n * RECIP_TEN) >> RECIP_SHIFT == n / 10 for any 32-bit n
    localparam logic [NUMBER_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                  RECIP_SHIFT = 35;

    typedef struct packed {
        logic signed [NUMBER_W-1:0] number;
        logic [CODE_W-1:0]          pad_code;
        logic                       pad_decoded;
        logic signed [POINT_W-1:0]  point_position;
    } in_item_t;

    typedef struct packed {
        logic [DIGIT_INDEX_W-1:0] digit_index;
        logic [CODE_W-1:0]        digit_code;
        logic                     decode_on;
        logic                     last;
        logic                     error_code;
    } out_item_t;

    typedef struct packed {
        logic load;    // capture input item, start conversion
        logic mul;     // multiply magnitude by reciprocal
        logic div;     // finish one divide step, store the digit
        logic fin;     // work out layout flags, rewind emit counter
        logic emit;    // load next digit into the output register
    } cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic digits_full;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/sndc_ctrl.sv
// Sequencer for conversion and digit emission.
`default_nettype none

module sndc_ctrl
    import sndc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // no transfer while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (status.mag_zero || status.digits_full) begin
                    state_next = S_FIN;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div    = 1'b1;
                state_next = S_MUL;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/sndc_datapath.sv
// Divide-by-ten digit extraction, digit store, layout flags and output register.
`default_nettype none

module sndc_datapath
    import sndc_pkg::*;
#(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire in_item_t               s_data,
    output out_item_t                   m_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CODE_W-1:0]      cfg_data,
    input  wire cmd_t                   cmd,
    output status_t                     status
);

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CW = $clog2(NUM_DIGITS + 1);
    localparam logic [CW-1:0]        N_CNT  = CW'(NUM_DIGITS);
    localparam logic [IW-1:0]        N_LAST = IW'(NUM_DIGITS - 1);
    localparam logic signed [8:0]    N_S    = 9'(NUM_DIGITS);

    // Configuration registers
    logic [CODE_W-1:0] zero_code_reg, dash_code_reg, point_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_code_reg  <= ZERO_CODE_RST;
            dash_code_reg  <= DASH_CODE_RST;
            point_mask_reg <= POINT_MASK_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ZERO_CODE:  zero_code_reg  <= cfg_data;
                CFG_DASH_CODE:  dash_code_reg  <= cfg_data;
                CFG_POINT_MASK: point_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item registers
    logic [NUMBER_W-1:0]       mag_reg;
    logic [2*NUMBER_W-1:0]     prod_reg;
    logic                      neg_reg;
    logic [CODE_W-1:0]         pad_code_reg;
    logic                      pad_dec_reg;
    logic signed [POINT_W-1:0] pp_reg;
    logic [BCD_W-1:0]          digit_reg [NUM_DIGITS];
    logic [CW-1:0]             dm_reg;
    logic [CW-1:0]             zend_reg;
    logic                      err_reg;
    logic                      point_on_reg;
    logic [IW-1:0]             emit_cnt_reg;

    logic [NUMBER_W-1:0] raw_u;
    logic [NUMBER_W-1:0] quot;
    logic [NUMBER_W-1:0] rem_full;

    assign raw_u    = NUMBER_W'(s_data.number);
    assign quot     = NUMBER_W'(prod_reg >> RECIP_SHIFT);
    assign rem_full = mag_reg - ((quot << 3) + (quot << 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg      <= raw_u[NUMBER_W-1];
            mag_reg      <= raw_u[NUMBER_W-1] ? (NUMBER_W'(0) - raw_u) : raw_u;
            pad_code_reg <= s_data.pad_code;
            pad_dec_reg  <= s_data.pad_decoded;
            pp_reg       <= s_data.point_position;
        end else if (cmd.div) begin
            mag_reg <= quot;
        end
        if (cmd.mul) begin
            prod_reg <= (2*NUMBER_W)'(mag_reg) * (2*NUMBER_W)'(RECIP_TEN);
        end
        if (cmd.div) begin
            digit_reg[dm_reg[IW-1:0]] <= rem_full[BCD_W-1:0];
        end
    end

    // Layout: magnitude digits, then zeros up to the point, then dash, then padding
    logic signed [8:0] pp1, dm_s, zmax, pp_s;
    logic [CW-1:0]     zend_next;
    logic              err_next;

    always_comb begin
        pp_s      = 9'(pp_reg);
        pp1       = pp_s + 9'sd1;
        dm_s      = $signed(9'(dm_reg));
        zmax      = (pp1 > dm_s) ? pp1 : dm_s;
        zend_next = (zmax >= N_S) ? N_CNT : CW'(zmax);
        err_next  = (neg_reg && (zend_next == N_CNT)) || (pp_s >= N_S);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dm_reg       <= '0;
            emit_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                dm_reg <= '0;
            end else if (cmd.div) begin
                dm_reg <= dm_reg + CW'(1);
            end
            if (cmd.fin) begin
                emit_cnt_reg <= '0;
            end else if (cmd.emit) begin
                emit_cnt_reg <= emit_cnt_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            zend_reg     <= zend_next;
            err_reg      <= err_next;
            point_on_reg <= !err_next && (pp_s >= 9'sd0) && (pp_s < N_S);
        end
    end

    // Code for the digit under the emit counter
    out_item_t       item;
    logic [CW-1:0]   cnt_ext;
    logic            is_last;

    always_comb begin
        cnt_ext = CW'(emit_cnt_reg);
        is_last = (emit_cnt_reg == N_LAST);
        item    = '0;
        item.digit_index = DIGIT_INDEX_W'(emit_cnt_reg);
        if (cnt_ext < dm_reg) begin
            item.digit_code = CODE_W'(digit_reg[emit_cnt_reg]);
            item.decode_on  = 1'b1;
        end else if (cnt_ext < zend_reg) begin
            item.digit_code = zero_code_reg;
            item.decode_on  = 1'b1;
        end else if (neg_reg && (cnt_ext == zend_reg)) begin
            item.digit_code = dash_code_reg;
            item.decode_on  = 1'b1;
        end else begin
            item.digit_code = pad_code_reg;
            item.decode_on  = pad_dec_reg;
        end
        if (point_on_reg && (emit_cnt_reg == pp_reg[IW-1:0])) begin
            item.digit_code = item.digit_code | point_mask_reg;
        end
        item.last       = is_last;
        item.error_code = is_last && err_reg;
    end

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.mag_zero    = (mag_reg == '0);
    assign status.digits_full = (dm_reg == N_CNT);
    assign status.out_free    = !m_valid_reg || m_ready;
    assign status.emit_last   = is_last;

endmodule

`default_nettype wire

### rtl/core/signed_number_to_digit_codes.sv
// Top level: signed number to per-digit display codes, least significant first.
// Sequence: after an input transfer, one multiply and one divide-by-ten step per
//   magnitude digit kept (up to min(10, NUM_DIGITS)), then the layout flags;
//   results then follow one per cycle while the sink is ready, NUM_DIGITS in all.
// A new item is taken only after the last result of the previous one enters the output register.
// Reset: synchronous active-low aresetn; config registers return to 0, 10, 128.
`default_nettype none

module signed_number_to_digit_codes
    import sndc_pkg::*;
#(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CODE_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    // register writes are dropped during reset, so none is accepted then
    assign cfg_ready = aresetn;

    sndc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sndc_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

### bench/tb_signed_number_to_digit_codes.sv
// Self-checking testbench for signed_number_to_digit_codes: directed table plus random numbers.
`timescale 1ns / 100ps

module tb_signed_number_to_digit_codes
    import sndc_pkg::*;
();

    localparam int ND             = DEF_NUM_DIGITS;
    localparam int LONG_HOLD      = 300;
    localparam int END_SLACK      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_DIR        = 20;

    typedef struct packed {
        logic signed [NUMBER_W-1:0] number;
        logic [CODE_W-1:0]          pad;
        logic                       pad_dec;
        logic signed [POINT_W-1:0]  point;
        logic                       typed;
        logic [ND*CODE_W-1:0]       codes;  // digit i in bits [8i+7:8i]
        logic [ND-1:0]              decs;
        logic                       err;
    } directed_row_t;

    // Typed rows assume the reset register values: zero 0, dash 10, point 0x80.
    localparam directed_row_t DIR_ROWS [NUM_DIR] = '{
        '{0,            8'h0F, 1'b1, -8'sd1,   1'b1, 64'h0F0F0F0F0F0F0F0F, 8'hFF, 1'b0},
        '{12345678,     8'h00, 1'b0, -8'sd1,   1'b1, 64'h0102030405060708, 8'hFF, 1'b0},
        '{32'h7FFFFFFF, 8'hFF, 1'b1, -8'sd1,   1'b1, 64'h0407040803060407, 8'hFF, 1'b0},
        '{32'h80000000, 8'h00, 1'b0, -8'sd1,   1'b1, 64'h0407040803060408, 8'hFF, 1'b1},
        '{-1,           8'h20, 1'b0, -8'sd1,   1'b1, 64'h2020202020200A01, 8'h03, 1'b0},
        '{0,            8'h55, 1'b0, 8'sd0,    1'b1, 64'h5555555555555580, 8'h01, 1'b0},
        '{5,            8'h00, 1'b0, 8'sd7,    1'b1, 64'h8000000000000005, 8'hFF, 1'b0},
        '{5,            8'h33, 1'b0, 8'sd8,    1'b1, 64'h0000000000000005, 8'hFF, 1'b1},
        '{5,            8'hCC, 1'b1, 8'sd127,  1'b1, 64'h0000000000000005, 8'hFF, 1'b1},
        '{5,            8'hFF, 1'b1, -8'sd128, 1'b1, 64'hFFFFFFFFFFFFFF05, 8'hFF, 1'b0},
        '{-1234567,     8'hC3, 1'b1, -8'sd1,   1'b0, 64'h0, 8'h00, 1'b0},
        '{-12345678,    8'h77, 1'b1, -8'sd1,   1'b1, 64'h0102030405060708, 8'hFF, 1'b1},
        '{-5,           8'h3C, 1'b0, 8'sd3,    1'b0, 64'h0, 8'h00, 1'b0},
        '{99999999,     8'h00, 1'b0, 8'sd2,    1'b0, 64'h0, 8'h00, 1'b0},
        '{-7,           8'h11, 1'b1, 8'sd7,    1'b1, 64'h0000000000000007, 8'hFF, 1'b1},
        '{10,           8'hAA, 1'b1, -8'sd1,   1'b0, 64'h0, 8'h00, 1'b0},
        '{0,            8'h00, 1'b0, -8'sd1,   1'b1, 64'h0000000000000000, 8'h00, 1'b0},
        '{1000000000,   8'h5A, 1'b0, 8'sd4,    1'b0, 64'h0, 8'h00, 1'b0},
        '{-2147483647,  8'hA5, 1'b1, 8'sd0,    1'b0, 64'h0, 8'h00, 1'b0},
        '{-99,          8'h81, 1'b0, 8'sd1,    1'b0, 64'h0, 8'h00, 1'b0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ZERO_CODE;
    logic [CODE_W-1:0]      cfg_data = '0;

    logic [CODE_W-1:0] zero_code_q  = ZERO_CODE_RST;
    logic [CODE_W-1:0] dash_code_q  = DASH_CODE_RST;
    logic [CODE_W-1:0] point_mask_q = POINT_MASK_RST;

    out_item_t expected_digits[$];
    int        fail_count = 0;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;
    int        hold_requests = 0;
    int        stall_cycles = 0;

    signed_number_to_digit_codes u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Digit codes for one number under the current register values.
    function automatic void predict_digits(input in_item_t it);
        logic [CODE_W-1:0]   code [ND];
        logic                dec  [ND];
        logic [NUMBER_W-1:0] mag;
        logic                neg;
        logic                off_display;
        int                  pos;
        int                  pt;
        int                  i;
        out_item_t           r;
        neg = it.number[NUMBER_W-1];
        mag = it.number;
        if (neg) begin
            mag = ~mag + 1'b1;  // most negative value stays 0x80000000, read as unsigned
        end
        pt = $signed(it.point_position);
        off_display = 1'b0;
        pos = 0;
        for (i = 0; i < ND; i++) begin
            code[i] = '0;
            dec[i] = 1'b0;
        end
        while (pos < ND && mag != 0) begin
            code[pos] = CODE_W'(mag % 32'd10);
            dec[pos] = 1'b1;
            mag = mag / 32'd10;
            pos++;
        end
        while (pos <= pt && pos < ND) begin
            code[pos] = zero_code_q;
            dec[pos] = 1'b1;
            pos++;
        end
        if (neg) begin
            if (pos < ND) begin
                code[pos] = dash_code_q;
                dec[pos] = 1'b1;
                pos++;
            end else begin
                off_display = 1'b1;
            end
        end
        if (!off_display) begin
            while (pos < ND) begin
                code[pos] = it.pad_code;
                dec[pos] = it.pad_decoded;
                pos++;
            end
            if (pt >= ND) begin
                off_display = 1'b1;
            end else if (pt >= 0) begin
                code[pt] = code[pt] | point_mask_q;
            end
        end
        for (i = 0; i < ND; i++) begin
            r.digit_index = DIGIT_INDEX_W'(i);
            r.digit_code  = code[i];
            r.decode_on   = dec[i];
            r.last        = (i == ND - 1);
            r.error_code  = (i == ND - 1) && off_display;
            expected_digits.push_back(r);
        end
    endfunction

    function automatic void push_typed_digits(input logic [ND*CODE_W-1:0] codes,
                                              input logic [ND-1:0] decs, input logic err);
        out_item_t r;
        int        i;
        for (i = 0; i < ND; i++) begin
            r.digit_index = DIGIT_INDEX_W'(i);
            r.digit_code  = codes[i*CODE_W +: CODE_W];
            r.decode_on   = decs[i];
            r.last        = (i == ND - 1);
            r.error_code  = (i == ND - 1) && err;
            expected_digits.push_back(r);
        end
    endfunction

    function automatic in_item_t random_number();
        in_item_t         it;
        int unsigned      ndig;
        longint unsigned  span;
        logic [NUMBER_W-1:0] mag;
        case ($urandom_range(9))
            0, 1: begin
                it.number = $urandom;
            end
            2: begin
                case ($urandom_range(4))
                    0: it.number = 0;
                    1: it.number = 1;
                    2: it.number = -1;
                    3: it.number = 32'h7FFFFFFF;
                    default: it.number = 32'h80000000;
                endcase
            end
            default: begin
                ndig = $urandom_range(9, 1);
                span = 1;
                repeat (ndig) span = span * 10;
                mag = $urandom_range(32'(span - 1));
                if ($urandom_range(1) == 1) begin
                    mag = ~mag + 1'b1;
                end
                it.number = mag;
            end
        endcase
        if ($urandom_range(7) == 0) begin
            it.point_position = POINT_W'($urandom);
        end else begin
            it.point_position = POINT_W'($urandom_range(9) - 1);
        end
        it.pad_code = CODE_W'($urandom);
        it.pad_decoded = 1'($urandom);
        return it;
    endfunction

    // Offers one number, with random idle cycles first; returns at the transfer edge.
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_digits.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CODE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ZERO_CODE:  zero_code_q = val;
            CFG_DASH_CODE:  dash_code_q = val;
            CFG_POINT_MASK: point_mask_q = val;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [CODE_W-1:0] zero_val,
                                  input logic [CODE_W-1:0] dash_val,
                                  input logic [CODE_W-1:0] mask_val);
        write_reg(CFG_ZERO_CODE, zero_val);
        write_reg(CFG_DASH_CODE, dash_val);
        write_reg(CFG_POINT_MASK, mask_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_numbers(input int count, input int hold_at, input int pause_at);
        in_item_t it;
        int       n;
        for (n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_requests++;
            end
            if (n == pause_at) begin
                wait_drained();
            end
            it = random_number();
            send_item(it);
            predict_digits(it);
        end
    endtask

    function automatic void report_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        fail_count++;
    endfunction

    function automatic void check_digit(input out_item_t got);
        out_item_t want;
        if (expected_digits.size() == 0) begin
            $display("%0t: digit transfer with nothing expected, actual %p", $time, got);
            fail_count++;
            return;
        end
        want = expected_digits.pop_front();
        if (got.digit_index !== want.digit_index)
            report_field("digit_index", 8'(want.digit_index), 8'(got.digit_index));
        if (got.digit_code !== want.digit_code)
            report_field("digit_code", want.digit_code, got.digit_code);
        if (got.decode_on !== want.decode_on)
            report_field("decode_on", 8'(want.decode_on), 8'(got.decode_on));
        if (got.last !== want.last)
            report_field("last", 8'(want.last), 8'(got.last));
        if (got.error_code !== want.error_code)
            report_field("error_code", 8'(want.error_code), 8'(got.error_code));
    endfunction

    // Result side: checks each transfer, then picks m_ready for the next edge.
    initial begin
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_digit(m_data);
            end
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_signed_number_to_digit_codes: FAIL");
            $finish;
        end
    end

    initial begin
        directed_row_t row;
        in_item_t      it;
        int            k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 20;
        sink_idle_pct = 57;
        for (k = 0; k < NUM_DIR; k++) begin
            row = DIR_ROWS[k];
            it.number = row.number;
            it.pad_code = row.pad;
            it.pad_decoded = row.pad_dec;
            it.point_position = row.point;
            send_item(it);
            if (row.typed) begin
                push_typed_digits(row.codes, row.decs, row.err);
            end else begin
                predict_digits(it);
            end
        end

        // long receiver hold while numbers keep coming: block fills and backs up
        wait_drained();
        write_settings(8'hFF, 8'h00, 8'h00);
        send_random_numbers(145, 20, -1);

        wait_drained();
        src_idle_pct = 57;
        sink_idle_pct = 20;
        write_settings(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
        send_random_numbers(145, -1, 60);

        wait_drained();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_settings(8'h00, 8'hFF, 8'hFF);
        send_random_numbers(145, -1, -1);

        wait_drained();
        repeat (END_SLACK) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_signed_number_to_digit_codes: PASS");
        end else begin
            $display("tb_signed_number_to_digit_codes: FAIL");
        end
        $finish;
    end

endmodule
